>>> hw/rtl/maps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maps_pkg: shared types and constants for the masked aligned pattern search
// Register map, field widths and the compare configuration bundle.
// ----------------------------------------------------------------------------
package maps_pkg;

	// Field and register widths
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int OFS_W       = 32;
	localparam int STEP_W      = 16;
	localparam int PLEN_W      = 5;
	localparam int NEEDLE_BYTES = 16;
	localparam int NEEDLE_W    = 8 * NEEDLE_BYTES;

	// Default window depth (1 to NEEDLE_BYTES)
	localparam int MAX_PATTERN_DEF = 16;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEEDLE_LO  = 3'd0,
		CFG_NEEDLE_HI  = 3'd1,
		CFG_MASK_LO    = 3'd2,
		CFG_MASK_HI    = 3'd3,
		CFG_MASK_EN    = 3'd4,
		CFG_PAT_LEN    = 3'd5,
		CFG_ALIGN_STEP = 3'd6,
		CFG_START_OFS  = 3'd7
	} cfg_idx_t;

	// Everything the window compare needs from the register file
	typedef struct packed {
		logic [NEEDLE_W-1:0] needle;
		logic [NEEDLE_W-1:0] mask;
		logic                mask_en;
	} cmp_cfg_t;

endpackage

>>> hw/rtl/maps_window_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maps_window_cmp: parallel masked compare of the byte window with the needle
// Needle byte i lines up with window entry len-1-i (entry 0 is the newest).
// ----------------------------------------------------------------------------
module maps_window_cmp import maps_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	localparam int LEN_W = $clog2(MAX_PATTERN + 1),
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
	input  logic [MAX_PATTERN-1:0][7:0] window,
	input  logic [LEN_W-1:0]            len,
	input  cmp_cfg_t                    cfg,
	output logic                        match
);

	// One byte lane per needle position, all independent
	always_comb begin
		logic [LEN_W-1:0] idx_full;
		logic [IDX_W-1:0] idx;
		logic [7:0]       w_byte;
		logic [7:0]       n_byte;
		logic [7:0]       m_byte;
		match = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			idx_full = len - LEN_W'(1) - LEN_W'(i);
			idx      = idx_full[IDX_W-1:0];
			w_byte   = window[idx];
			n_byte   = cfg.needle[8*i +: 8];
			m_byte   = cfg.mask_en ? cfg.mask[8*i +: 8] : 8'hFF;
			if ((LEN_W'(i) < len) && ((w_byte & m_byte) != (n_byte & m_byte))) begin
				match = 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/masked_aligned_pattern_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_aligned_pattern_search: streamed masked byte pattern search
// Output: a result word is registered in the output register, or in the skid
//   entry while the output word is held by out_stall.
// Throughput: one byte per cycle while in_stall is low; the window compare
//   is a single parallel stage between search state and output register.
// Reset: arst_n clears registers and search state at once; no clearing pass.
// ----------------------------------------------------------------------------
module masked_aligned_pattern_search import maps_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// image byte stream
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            image_byte,
	input  logic                  last_byte,
	// search result
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  found,
	output logic [OFS_W-1:0]      match_offset
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	// Register file
	logic [CFG_DATA_W-1:0] needle_lo_q, needle_hi_q, mask_lo_q, mask_hi_q;
	logic                  mask_en_q;
	logic [PLEN_W-1:0]     pat_len_q;
	logic [STEP_W-1:0]     align_step_q;
	logic [OFS_W-1:0]      start_ofs_q;

	// Search state
	logic [MAX_PATTERN-1:0][7:0] window_q;
	logic [MAX_PATTERN-1:0][7:0] window_nx;
	logic [OFS_W-1:0]            count_q;
	logic [STEP_W-1:0]           phase_q;
	logic                        done_q;

	// Output register and skid entry
	logic             out_valid_q, skid_valid_q;
	logic             out_found_q, skid_found_q;
	logic [OFS_W-1:0] out_ofs_q, skid_ofs_q;

	logic             in_acc, out_take;
	logic [LEN_W-1:0] len_eff, len_m1;
	logic [STEP_W-1:0] step_eff;
	logic             fits, match, hit;
	logic [OFS_W-1:0] cand;
	logic [STEP_W:0]  phase_inc;
	logic [STEP_W-1:0] phase_nx;
	logic             res_valid;
	logic [OFS_W-1:0] res_ofs;
	cmp_cfg_t         cmp_cfg;

	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !out_stall;

	assign out_valid    = out_valid_q;
	assign found        = out_found_q;
	assign match_offset = out_ofs_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_lo_q  <= '0;
			needle_hi_q  <= '0;
			mask_lo_q    <= '0;
			mask_hi_q    <= '0;
			mask_en_q    <= 1'b0;
			pat_len_q    <= PLEN_W'(1);
			align_step_q <= STEP_W'(1);
			start_ofs_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_NEEDLE_LO:  needle_lo_q  <= cfg_data;
				CFG_NEEDLE_HI:  needle_hi_q  <= cfg_data;
				CFG_MASK_LO:    mask_lo_q    <= cfg_data;
				CFG_MASK_HI:    mask_hi_q    <= cfg_data;
				CFG_MASK_EN:    mask_en_q    <= cfg_data[0];
				CFG_PAT_LEN:    pat_len_q    <= cfg_data[PLEN_W-1:0];
				CFG_ALIGN_STEP: align_step_q <= cfg_data[STEP_W-1:0];
				CFG_START_OFS:  start_ofs_q  <= cfg_data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective length (zero reads as one, saturate at window depth) and step
	always_comb begin
		if (pat_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (pat_len_q > PLEN_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = LEN_W'(pat_len_q);
		end
		step_eff = (align_step_q == '0) ? STEP_W'(1) : align_step_q;
	end

	// Window after shifting in the new byte
	always_comb begin
		window_nx[0] = image_byte;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			window_nx[k] = window_q[k-1];
		end
	end

	// Candidate offset and alignment phase
	assign len_m1    = len_eff - LEN_W'(1);
	assign fits      = {1'b0, count_q} >= ({1'b0, start_ofs_q} + (OFS_W+1)'(len_m1));
	assign cand      = count_q - OFS_W'(len_m1);
	assign phase_inc = {1'b0, phase_q} + (STEP_W+1)'(1);

	always_comb begin
		if (cand == start_ofs_q) begin
			phase_nx = '0;
		end else if (phase_inc >= {1'b0, step_eff}) begin
			phase_nx = '0;
		end else begin
			phase_nx = phase_inc[STEP_W-1:0];
		end
	end

	assign cmp_cfg.needle  = {needle_hi_q, needle_lo_q};
	assign cmp_cfg.mask    = {mask_hi_q, mask_lo_q};
	assign cmp_cfg.mask_en = mask_en_q;

	maps_window_cmp #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cmp (
		.window(window_nx),
		.len   (len_eff),
		.cfg   (cmp_cfg),
		.match (match)
	);

	// A result word: first match, or not-found on the final byte
	assign hit       = fits && (phase_nx == '0) && match;
	assign res_valid = in_acc && !done_q && (hit || last_byte);
	assign res_ofs   = hit ? cand : '0;

	// Search state update; the final byte returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			count_q  <= '0;
			phase_q  <= '0;
			done_q   <= 1'b0;
		end else if (in_acc) begin
			if (last_byte) begin
				window_q <= '0;
				count_q  <= '0;
				phase_q  <= '0;
				done_q   <= 1'b0;
			end else if (!done_q) begin
				window_q <= window_nx;
				count_q  <= count_q + OFS_W'(1);
				if (fits) begin
					phase_q <= phase_nx;
				end
				if (hit) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Output and skid valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_take) begin
				out_valid_q  <= skid_valid_q || res_valid;
				skid_valid_q <= 1'b0;
			end else if (res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Output and skid word data
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_found_q <= skid_found_q;
				out_ofs_q   <= skid_ofs_q;
			end else if (res_valid) begin
				out_found_q <= hit;
				out_ofs_q   <= res_ofs;
			end
		end else if (res_valid) begin
			skid_found_q <= hit;
			skid_ofs_q   <= res_ofs;
		end
	end

	// Skid entry is only ever filled behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word valid with empty output register");

	// A not-found word carries a zero offset
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_ofs_q == '0))
		else $error("not-found word with nonzero offset");

	// After a match no further word is produced for the same image
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !res_valid)
		else $error("result produced after match");

	// The final byte restarts the search
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_byte) |=> (count_q == '0 && phase_q == '0 && !done_q))
		else $error("search state not cleared after final byte");

endmodule

>>> tb/masked_aligned_pattern_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_aligned_pattern_search_tb: self-checking bench for the pattern search
// Streams images through the byte port under random stalls on both sides.
// A scoreboard class tracks the search state, predicts one result word per
// image, and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module masked_aligned_pattern_search_tb import maps_pkg::*; ;

	// Scoreboard: shadow registers, search state and pending results
	class search_ledger;
		typedef struct {
			logic        found;
			logic [31:0] offset;
		} hit_t;

		logic [63:0] needle_lo, needle_hi, mask_lo, mask_hi;
		bit          mask_en;
		bit   [4:0]  pat_len;
		bit   [15:0] step;
		bit   [31:0] start_ofs;

		bit   [7:0]  window [16];
		bit   [31:0] count;
		bit   [15:0] phase;
		bit          done;

		hit_t        hits [$];
		int          errors;
		int          results;
		int          founds;

		function new();
			needle_lo = '0;
			needle_hi = '0;
			mask_lo   = '0;
			mask_hi   = '0;
			mask_en   = 1'b0;
			pat_len   = 5'd1;
			step      = 16'd1;
			start_ofs = '0;
			errors    = 0;
			results   = 0;
			founds    = 0;
			clear_search();
		endfunction

		function void clear_search();
			foreach (window[k])
				window[k] = 8'h00;
			count = '0;
			phase = '0;
			done  = 1'b0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [63:0] v);
			case (idx)
				CFG_NEEDLE_LO:  needle_lo = v;
				CFG_NEEDLE_HI:  needle_hi = v;
				CFG_MASK_LO:    mask_lo   = v;
				CFG_MASK_HI:    mask_hi   = v;
				CFG_MASK_EN:    mask_en   = v[0];
				CFG_PAT_LEN:    pat_len   = v[4:0];
				CFG_ALIGN_STEP: step      = v[15:0];
				CFG_START_OFS:  start_ofs = v[31:0];
				default: ;
			endcase
		endfunction

		// window entry len-1 is the oldest byte, compared with needle byte 0
		function bit window_hit(int unsigned len);
			logic [127:0] nd;
			logic [127:0] mk;
			bit   [7:0]   w;
			bit   [7:0]   n;
			nd = {needle_hi, needle_lo};
			mk = {mask_hi, mask_lo};
			for (int i = 0; i < len; i++) begin
				w = window[4'(len - 1 - i)];
				n = nd[8*i +: 8];
				if (mask_en) begin
					w = w & mk[8*i +: 8];
					n = n & mk[8*i +: 8];
				end
				if (w != n)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		// one accepted image word: advance the search, queue any result
		function void note_word(bit [7:0] b, bit last);
			int unsigned len;
			int unsigned stp;
			bit   [31:0] c;
			bit          hit;
			hit_t        h;
			hit = 1'b0;
			if (!done) begin
				len = (pat_len == 5'd0) ? 1 : ((pat_len > 5'd16) ? 16 : 32'(pat_len));
				stp = (step == 16'd0) ? 1 : 32'(step);
				for (int k = 15; k > 0; k--)
					window[k] = window[k-1];
				window[0] = b;
				if (64'(count) >= 64'(start_ofs) + 64'(len) - 64'd1) begin
					c = count - 32'(len - 1);
					if (c == start_ofs)
						phase = '0;
					else if (32'(phase) + 32'd1 >= stp)
						phase = '0;
					else
						phase = phase + 16'd1;
					if (phase == 16'd0 && window_hit(len)) begin
						done     = 1'b1;
						h.found  = 1'b1;
						h.offset = c;
						hits.push_back(h);
						hit = 1'b1;
					end
				end
				count = count + 32'd1;
				if (last && !hit) begin
					h.found  = 1'b0;
					h.offset = '0;
					hits.push_back(h);
				end
			end
			if (last)
				clear_search();
		endfunction

		function void check_result(logic f, logic [31:0] ofs);
			hit_t h;
			if (hits.size() == 0) begin
				$error("unexpected result word: found=%0b match_offset=%0d", f, ofs);
				errors++;
				return;
			end
			h = hits.pop_front();
			results++;
			if (f === 1'b1)
				founds++;
			if (f !== h.found) begin
				$error("found: expected %0b, got %0b", h.found, f);
				errors++;
			end
			if (ofs !== h.offset) begin
				$error("match_offset: expected %0d, got %0d", h.offset, ofs);
				errors++;
			end
		endfunction

		function int pending();
			return hits.size();
		endfunction

		function void close_out();
			if (hits.size() != 0) begin
				$error("%0d result words never arrived", hits.size());
				errors += hits.size();
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            image_byte;
	logic                  last_byte;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  found;
	logic [OFS_W-1:0]      match_offset;

	search_ledger          ledger;
	logic [CFG_DATA_W-1:0] cfg_shadow [8];
	int                    send_idle_pct = 0;
	int                    recv_idle_pct = 0;
	int                    words_sent    = 0;
	int                    images        = 0;
	int                    settings      = 0;

	masked_aligned_pattern_search u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.image_byte   (image_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.match_offset (match_offset)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side: random stall, check every accepted word
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (out_valid && !out_stall)
			ledger.check_result(found, match_offset);
	end

	// Hand one image word over, with random idle cycles before it
	task send_byte(input bit [7:0] b, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		image_byte <= b;
		last_byte  <= last;
		do
			@(posedge clk);
		while (in_stall);
		ledger.note_word(b, last);
		words_sent++;
	endtask

	// Hold the input until every expected word is out, plus the pipeline delay
	task settle();
		in_valid <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the selected registers from the shadow copy
	task push_cfg(input bit [7:0] which);
		cfg_idx_t r;
		r = r.first();
		repeat (r.num()) begin
			if (which[r]) begin
				cfg_write <= 1'b1;
				cfg_index <= r;
				cfg_data  <= cfg_shadow[r];
				@(posedge clk);
				ledger.set_reg(r, cfg_shadow[r]);
			end
			r = r.next();
		end
		cfg_write <= 1'b0;
	endtask

	// New random setting, extremes included now and then
	task rand_settings();
		cfg_shadow[CFG_NEEDLE_LO] = {$urandom, $urandom};
		cfg_shadow[CFG_NEEDLE_HI] = {$urandom, $urandom};
		case ($urandom_range(3))
			0:       cfg_shadow[CFG_MASK_LO] = '0;
			1:       cfg_shadow[CFG_MASK_LO] = '1;
			default: cfg_shadow[CFG_MASK_LO] = {$urandom, $urandom};
		endcase
		case ($urandom_range(3))
			0:       cfg_shadow[CFG_MASK_HI] = '0;
			1:       cfg_shadow[CFG_MASK_HI] = '1;
			default: cfg_shadow[CFG_MASK_HI] = {$urandom, $urandom};
		endcase
		cfg_shadow[CFG_MASK_EN] = 64'($urandom_range(1));
		case ($urandom_range(9))
			0:       cfg_shadow[CFG_PAT_LEN] = 64'd0;
			1:       cfg_shadow[CFG_PAT_LEN] = 64'($urandom_range(31, 17));
			2:       cfg_shadow[CFG_PAT_LEN] = 64'd16;
			default: cfg_shadow[CFG_PAT_LEN] = 64'($urandom_range(6, 1));
		endcase
		case ($urandom_range(9))
			0:       cfg_shadow[CFG_ALIGN_STEP] = 64'd0;
			1:       cfg_shadow[CFG_ALIGN_STEP] = 64'd65535;
			2:       cfg_shadow[CFG_ALIGN_STEP] = 64'($urandom_range(65535));
			default: cfg_shadow[CFG_ALIGN_STEP] = 64'($urandom_range(5, 1));
		endcase
		case ($urandom_range(9))
			0:       cfg_shadow[CFG_START_OFS] = 64'hFFFF_FFFF;
			1:       cfg_shadow[CFG_START_OFS] = 64'($urandom);
			2, 3:    cfg_shadow[CFG_START_OFS] = 64'd0;
			default: cfg_shadow[CFG_START_OFS] = 64'($urandom_range(12));
		endcase
	endtask

	// Random image; often the needle is planted on a candidate offset
	task feed_image(input int n);
		bit   [7:0]   img [];
		logic [127:0] nd;
		logic [127:0] mk;
		int           len;
		int           stp;
		longint       start;
		longint       c;
		bit           sparse;
		nd     = {cfg_shadow[CFG_NEEDLE_HI], cfg_shadow[CFG_NEEDLE_LO]};
		mk     = {cfg_shadow[CFG_MASK_HI], cfg_shadow[CFG_MASK_LO]};
		len    = 32'(cfg_shadow[CFG_PAT_LEN][4:0]);
		len    = (len == 0) ? 1 : ((len > 16) ? 16 : len);
		stp    = 32'(cfg_shadow[CFG_ALIGN_STEP][15:0]);
		stp    = (stp == 0) ? 1 : stp;
		start  = longint'(cfg_shadow[CFG_START_OFS][31:0]);
		sparse = ($urandom_range(3) == 0);
		img    = new[n];
		foreach (img[i])
			img[i] = sparse ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
		if ($urandom_range(9) < 6 && start + len <= n) begin
			c = start + longint'($urandom_range(32'((n - len - start) / stp))) * stp;
			// sometimes one byte off the grid
			if ($urandom_range(4) == 0 && c + len < n)
				c++;
			for (int i = 0; i < len; i++) begin
				if (cfg_shadow[CFG_MASK_EN][0])
					img[c+i] = (8'($urandom) & ~mk[8*i +: 8]) | (nd[8*i +: 8] & mk[8*i +: 8]);
				else
					img[c+i] = nd[8*i +: 8];
			end
		end
		for (int i = 0; i < n; i++)
			send_byte(img[i], i == n - 1);
		images++;
	endtask

	// One idling profile: images with occasional setting changes
	task run_phase(input int sender_pct, input int receiver_pct, input int words);
		int first_word;
		int sel;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		first_word    = words_sent;
		while (words_sent - first_word < words) begin
			if ($urandom_range(3) == 0) begin
				settle();
				rand_settings();
				push_cfg(8'hFF);
				settings++;
			end
			sel = $urandom_range(19);
			if (sel == 0)
				feed_image($urandom_range(300, 120));
			else if (sel == 1)
				feed_image(1);
			else
				feed_image($urandom_range(32, 2));
		end
	endtask

	// Main sequence
	initial begin
		ledger = new();
		foreach (cfg_shadow[i])
			cfg_shadow[i] = '0;
		arst_n     <= 1'b0;
		cfg_write  <= 1'b0;
		cfg_index  <= CFG_NEEDLE_LO;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		image_byte <= 8'h00;
		last_byte  <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: one-byte needle of zero at offset 0
		send_byte(8'h00, 1'b1);
		settle();

		// zero length and step act as one; offset 0 lies before the start
		cfg_shadow[CFG_NEEDLE_LO]  = '1;
		cfg_shadow[CFG_NEEDLE_HI]  = 64'h0123_4567_89AB_CDEF;
		cfg_shadow[CFG_MASK_LO]    = '0;
		cfg_shadow[CFG_MASK_HI]    = '1;
		cfg_shadow[CFG_MASK_EN]    = 64'd0;
		cfg_shadow[CFG_PAT_LEN]    = 64'd0;
		cfg_shadow[CFG_ALIGN_STEP] = 64'd0;
		cfg_shadow[CFG_START_OFS]  = 64'd1;
		push_cfg(8'hFF);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hAB, 1'b1);
		settle();

		// image too short for the window; length above the limit
		cfg_shadow[CFG_PAT_LEN]   = 64'd31;
		cfg_shadow[CFG_START_OFS] = 64'hFFFF_FFFF;
		push_cfg((8'h1 << CFG_PAT_LEN) | (8'h1 << CFG_START_OFS));
		send_byte(8'h5A, 1'b1);
		settle();

		// mask turned on mid-image, then bytes after the match are dropped
		cfg_shadow[CFG_NEEDLE_LO]  = 64'h1234;
		cfg_shadow[CFG_MASK_LO]    = 64'hFFFF_FFFF_FFFF_FF00;
		cfg_shadow[CFG_PAT_LEN]    = 64'd2;
		cfg_shadow[CFG_ALIGN_STEP] = 64'd1;
		cfg_shadow[CFG_START_OFS]  = 64'd0;
		push_cfg(8'hFF);
		send_byte(8'h55, 1'b0);
		send_byte(8'h12, 1'b0);
		settle();
		cfg_shadow[CFG_MASK_EN] = 64'd1;
		push_cfg(8'h1 << CFG_MASK_EN);
		send_byte(8'h77, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		settle();

		// saturated length, widest step, mask clears every bit
		cfg_shadow[CFG_MASK_LO]    = '0;
		cfg_shadow[CFG_MASK_HI]    = '0;
		cfg_shadow[CFG_PAT_LEN]    = 64'd17;
		cfg_shadow[CFG_ALIGN_STEP] = 64'd65535;
		push_cfg(8'hFF);
		for (int i = 0; i < 16; i++)
			send_byte(8'($urandom), i == 15);
		settle();
		settings += 4;

		run_phase(37, 77, 600);
		run_phase(77, 37, 600);
		run_phase(0, 0, 600);
		settle();

		ledger.close_out();
		$display("Searched %0d images, %0d bytes, under %0d register settings.",
			images, words_sent, settings);
		$display("Checked %0d result words: %0d matches, %0d not found.",
			ledger.results, ledger.founds, ledger.results - ledger.founds);
		if (ledger.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$error("timeout: run did not complete");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
